/* rtl/bi_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the block interleaver.
// No dependencies; every other file of the block refers to this package.
package bi_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 7;

  // Output queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROW_COUNT    = 2'd0,
    REG_COLUMN_COUNT = 2'd1
  } reg_index_t;

  // Per-cycle command from the address front end to the bank memory
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic rd_last;
  } mem_cmd_t;

endpackage

/* rtl/bi_if.sv */
`timescale 1ns / 1ps
// Channel interfaces of the block interleaver: sample input, result output
// and configuration write. Depends on bi_pkg for the configuration widths.
interface bi_in_if #(parameter int DATA_WIDTH = 16);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface bi_out_if #(parameter int DATA_WIDTH = 16);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sample_out;
  logic                         block_end;

  modport source (output valid, output sample_out, output block_end, input ready);
  modport sink   (input valid, input sample_out, input block_end, output ready);
endinterface

interface bi_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bi_pkg::CFG_INDEX_W-1:0]   index;
  logic [bi_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/bi_front.sv */
`timescale 1ns / 1ps
// Front end of the block interleaver: size registers, write and read
// counters, bank select and memory address generation. Uses bi_pkg.
module bi_front #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64,
  parameter int DATA_WIDTH  = 16,
  parameter int ADDR_W      = 13
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bi_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bi_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                            accept,
  input  logic signed [DATA_WIDTH-1:0]    sample,
  output bi_pkg::mem_cmd_t                cmd,
  output logic [ADDR_W-1:0]               wr_addr,
  output logic [ADDR_W-1:0]               rd_addr,
  output logic signed [DATA_WIDTH-1:0]    wr_data
);

  localparam int RW   = $clog2(MAX_ROWS + 1);
  localparam int CW   = $clog2(MAX_COLUMNS + 1);
  localparam int RRW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RCW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int WPW  = ADDR_W - 1;
  localparam int SW   = RW + CW;
  localparam int LW   = RRW + CW + 1;
  localparam int ROW_RST = (MAX_ROWS < 8) ? MAX_ROWS : 8;
  localparam int COL_RST = (MAX_COLUMNS < 8) ? MAX_COLUMNS : 8;

  logic [RW-1:0]  row_cnt_r, row_cnt_nxt;
  logic [CW-1:0]  col_cnt_r, col_cnt_nxt;
  logic [WPW-1:0] wr_pos_r, wr_pos_nxt;
  logic [RRW-1:0] rd_row_r, rd_row_nxt;
  logic [RCW-1:0] rd_col_r, rd_col_nxt;
  logic           wr_bank_r, wr_bank_nxt;
  logic           primed_r, primed_nxt;

  logic [SW-1:0]  size;
  logic [LW-1:0]  rd_lin;
  logic           last_row;
  logic           last_col;
  logic           block_done;
  logic [RW-1:0]  row_wr;
  logic [CW-1:0]  col_wr;

  assign size       = SW'(row_cnt_r) * SW'(col_cnt_r);
  assign rd_lin     = LW'(rd_row_r) * LW'(col_cnt_r) + LW'(rd_col_r);
  assign last_row   = (32'(rd_row_r) + 32'd1) >= 32'(row_cnt_r);
  assign last_col   = (32'(rd_col_r) + 32'd1) >= 32'(col_cnt_r);
  assign block_done = (32'(wr_pos_r) + 32'd1) >= 32'(size);

  // Clamp register writes into the supported size range
  always_comb begin
    if (cfg_data == '0) begin
      row_wr = RW'(1);
      col_wr = CW'(1);
    end else begin
      row_wr = (32'(cfg_data) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(cfg_data);
      col_wr = (32'(cfg_data) > MAX_COLUMNS) ? CW'(MAX_COLUMNS) : CW'(cfg_data);
    end
  end

  always_comb begin
    row_cnt_nxt = row_cnt_r;
    col_cnt_nxt = col_cnt_r;
    wr_pos_nxt  = wr_pos_r;
    rd_row_nxt  = rd_row_r;
    rd_col_nxt  = rd_col_r;
    wr_bank_nxt = wr_bank_r;
    primed_nxt  = primed_r;

    if (cfg_we) begin
      case (cfg_index)
        bi_pkg::REG_ROW_COUNT:    row_cnt_nxt = row_wr;
        bi_pkg::REG_COLUMN_COUNT: col_cnt_nxt = col_wr;
        default: ;
      endcase
    end

    if (accept) begin
      if (primed_r) begin
        if (last_row) begin
          rd_row_nxt = '0;
          rd_col_nxt = last_col ? '0 : rd_col_r + RCW'(1);
        end else begin
          rd_row_nxt = rd_row_r + RRW'(1);
        end
      end
      wr_pos_nxt = wr_pos_r + WPW'(1);
      // Block full: swap banks and restart the read scan
      if (block_done) begin
        wr_pos_nxt  = '0;
        wr_bank_nxt = ~wr_bank_r;
        primed_nxt  = 1'b1;
        rd_row_nxt  = '0;
        rd_col_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= RW'(ROW_RST);
      col_cnt_r <= CW'(COL_RST);
      wr_pos_r  <= '0;
      rd_row_r  <= '0;
      rd_col_r  <= '0;
      wr_bank_r <= 1'b0;
      primed_r  <= 1'b0;
    end else begin
      row_cnt_r <= row_cnt_nxt;
      col_cnt_r <= col_cnt_nxt;
      wr_pos_r  <= wr_pos_nxt;
      rd_row_r  <= rd_row_nxt;
      rd_col_r  <= rd_col_nxt;
      wr_bank_r <= wr_bank_nxt;
      primed_r  <= primed_nxt;
    end
  end

  assign cmd.wr_en   = accept;
  assign cmd.rd_en   = accept & primed_r;
  assign cmd.rd_last = last_row & last_col;
  assign wr_addr     = {wr_bank_r, wr_pos_r};
  assign rd_addr     = {~wr_bank_r, rd_lin[WPW-1:0]};
  assign wr_data     = sample;

endmodule

/* rtl/bi_store.sv */
`timescale 1ns / 1ps
// Two-bank sample memory with one write port and one registered read port.
// Uses bi_pkg for the command struct.
module bi_store #(
  parameter int DATA_WIDTH = 16,
  parameter int ADDR_W     = 13
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bi_pkg::mem_cmd_t             cmd,
  input  logic [ADDR_W-1:0]            wr_addr,
  input  logic [ADDR_W-1:0]            rd_addr,
  input  logic signed [DATA_WIDTH-1:0] wr_data,
  output logic                         rd_valid,
  output logic signed [DATA_WIDTH-1:0] rd_data,
  output logic                         rd_last
);

  localparam int MEM_DEPTH = 2 ** ADDR_W;

  logic signed [DATA_WIDTH-1:0] mem [MEM_DEPTH];
  logic signed [DATA_WIDTH-1:0] rd_data_r;
  logic                         rd_last_r;
  logic                         rd_valid_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read and write always target opposite banks
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_last_r <= cmd.rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= cmd.rd_en;
    end
  end

  assign rd_valid = rd_valid_r;
  assign rd_data  = rd_data_r;
  assign rd_last  = rd_last_r;

endmodule

/* rtl/bi_queue.sv */
`timescale 1ns / 1ps
// Output queue of the block interleaver: holds read samples until the
// result channel takes them. Uses bi_pkg for its depth.
module bi_queue #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  logic signed [DATA_WIDTH-1:0]    push_data,
  input  logic                            push_last,
  output logic [bi_pkg::QUEUE_CW-1:0]     count,
  bi_out_if.source                        out_if
);

  logic signed [DATA_WIDTH-1:0]       data_r [bi_pkg::QUEUE_DEPTH];
  logic                               last_r [bi_pkg::QUEUE_DEPTH];
  logic [bi_pkg::QUEUE_AW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [bi_pkg::QUEUE_AW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [bi_pkg::QUEUE_CW-1:0]        count_r, count_nxt;
  logic                               pop;

  assign pop = out_if.valid & out_if.ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + bi_pkg::QUEUE_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + bi_pkg::QUEUE_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + bi_pkg::QUEUE_CW'(push) - bi_pkg::QUEUE_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r[wr_ptr_r] <= push_data;
      last_r[wr_ptr_r] <= push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign count             = count_r;
  assign out_if.valid      = (count_r != '0);
  assign out_if.sample_out = data_r[rd_ptr_r];
  assign out_if.block_end  = last_r[rd_ptr_r];

endmodule

/* rtl/block_interleaver.sv */
`timescale 1ns / 1ps
// Row-column block interleaver. Samples are written row by row into one of
// two banks of row_count x column_count entries and read back column by column
// from the other bank; the output stream lags the input by one whole block and
// block_end marks the last sample of each block. No result comes out until the
// first block has filled. One sample is accepted per cycle while input is not
// held off: each accepted sample costs one write and at most one read of the
// bank memory, which has one port of each kind. A result is registered in the
// memory read stage and then in the output queue; the four-entry output queue
// absorbs stalls on the result side, and input is held off while the queue and
// the memory read stage together hold four results.
// Write row_count and column_count only while the block is idle.
// Depends on bi_pkg, bi_if, bi_front, bi_store and bi_queue.
module block_interleaver #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64,
  parameter int DATA_WIDTH  = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  bi_cfg_if.sink   cfg_if,
  bi_in_if.sink    in_if,
  bi_out_if.source out_if
);

  localparam int BANK   = MAX_ROWS * MAX_COLUMNS;
  localparam int ADDR_W = ((BANK > 1) ? $clog2(BANK) : 1) + 1;

  bi_pkg::mem_cmd_t               cmd;
  logic [ADDR_W-1:0]              wr_addr;
  logic [ADDR_W-1:0]              rd_addr;
  logic signed [DATA_WIDTH-1:0]   wr_data;
  logic                           rd_valid;
  logic signed [DATA_WIDTH-1:0]   rd_data;
  logic                           rd_last;
  logic [bi_pkg::QUEUE_CW-1:0]    q_count;
  logic                           accept;

  assign cfg_if.ready = 1'b1;
  // Admit a sample only if its result is sure of a queue slot
  assign in_if.ready  = (32'(q_count) + 32'(rd_valid)) < bi_pkg::QUEUE_DEPTH;
  assign accept       = in_if.valid & in_if.ready;

  bi_front #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS),
    .DATA_WIDTH  (DATA_WIDTH),
    .ADDR_W      (ADDR_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_if.valid & cfg_if.ready),
    .cfg_index (cfg_if.index),
    .cfg_data  (cfg_if.data),
    .accept    (accept),
    .sample    (in_if.sample_in),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .wr_data   (wr_data)
  );

  bi_store #(
    .DATA_WIDTH (DATA_WIDTH),
    .ADDR_W     (ADDR_W)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr),
    .wr_data  (wr_data),
    .rd_valid (rd_valid),
    .rd_data  (rd_data),
    .rd_last  (rd_last)
  );

  bi_queue #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rd_valid),
    .push_data (rd_data),
    .push_last (rd_last),
    .count     (q_count),
    .out_if    (out_if)
  );

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(q_count) + 32'(rd_valid)) <= bi_pkg::QUEUE_DEPTH)
    else $error("output queue overfilled");

  a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |=> rd_valid)
    else $error("issued read did not reach the queue");

  a_read_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> (accept && cmd.wr_en && (wr_addr[ADDR_W-1] != rd_addr[ADDR_W-1])))
    else $error("read issued without a sample or into the write bank");
`endif

endmodule

/* tb/tb_block_interleaver.sv */
`timescale 1ns / 1ps
// Self-checking bench for block_interleaver: random and edge samples under
// changing matrix sizes and pacing, checked against an in-bench reorder model.
// Depends on bi_pkg, the bi_if channel interfaces and the block_interleaver RTL.
module tb_block_interleaver;

  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLUMNS = 64;
  localparam int DATA_WIDTH  = 16;
  localparam int BANK_DEPTH  = MAX_ROWS * MAX_COLUMNS;

  localparam int unsigned RESET_DIM      = 8;
  localparam int          RESET_CYCLES   = 12;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          DRAIN_CYCLES   = 20;
  localparam int          STALL_LIMIT    = 2000;
  localparam int          RANDOM_SAMPLES = 130;

  // Indexes outside the register map; the block must ignore them
  localparam logic [bi_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [bi_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

  localparam logic signed [DATA_WIDTH-1:0] EDGE_SAMPLES [6] = '{
    16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh5555, 16'shAAAA
  };

  typedef enum int unsigned {
    PACE_FREE,
    PACE_SENDER_IDLE,
    PACE_RECEIVER_STALL,
    PACE_BOTH_IDLE
  } pace_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] sample;
    logic                         block_end;
  } reordered_t;

  typedef struct packed {
    logic [bi_pkg::CFG_INDEX_W-1:0] index;
    logic [bi_pkg::CFG_DATA_W-1:0]  data;
  } reg_write_t;

  logic clk;
  logic rst_n;

  bi_cfg_if                           cfg_bus ();
  bi_in_if  #(.DATA_WIDTH(DATA_WIDTH)) in_bus ();
  bi_out_if #(.DATA_WIDTH(DATA_WIDTH)) out_bus ();

  block_interleaver #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLUMNS(MAX_COLUMNS),
    .DATA_WIDTH (DATA_WIDTH)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_if(cfg_bus),
    .in_if (in_bus),
    .out_if(out_bus)
  );

  // Stimulus waiting for the drivers
  logic signed [DATA_WIDTH-1:0] pending_samples[$];
  reg_write_t                   pending_reg_writes[$];

  // Interleaver model state
  logic signed [DATA_WIDTH-1:0] bank_mem [2][BANK_DEPTH];
  int unsigned rows_used = RESET_DIM;
  int unsigned cols_used = RESET_DIM;
  int unsigned wr_pos    = 0;
  int unsigned rd_row    = 0;
  int unsigned rd_col    = 0;
  bit          fill_bank = 1'b0;
  bit          bank_ready = 1'b0;
  reordered_t  reordered_samples[$];

  // Handshake bookkeeping
  bit          in_fired  = 1'b0;
  bit          cfg_fired = 1'b0;
  int unsigned samples_queued  = 0;
  int unsigned samples_taken   = 0;
  int unsigned reg_writes_queued = 0;
  int unsigned reg_writes_taken  = 0;
  int unsigned pending_results = 0;
  int unsigned results_checked = 0;
  int unsigned block_ends_seen = 0;
  int unsigned mismatches      = 0;
  int unsigned quiet_cycles    = 0;

  // Pacing
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned calm_left          = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned clamp_dim(logic [bi_pkg::CFG_DATA_W-1:0] v,
                                            int unsigned lim);
    if (v == '0) return 1;
    if (32'(v) > lim) return lim;
    return 32'(v);
  endfunction

  // Write one sample row-major into the fill bank; read the other bank
  // column-major once the first block has filled.
  function automatic void interleave_sample(logic signed [DATA_WIDTH-1:0] s);
    int unsigned block_len;
    int unsigned addr;
    bit          row_wrap;
    bit          col_wrap;
    reordered_t  r;
    block_len = rows_used * cols_used;
    if (bank_ready) begin
      addr        = (rd_row * cols_used + rd_col) % BANK_DEPTH;
      row_wrap    = (rd_row + 1 >= rows_used);
      col_wrap    = (rd_col + 1 >= cols_used);
      r.sample    = bank_mem[fill_bank ^ 1'b1][addr];
      r.block_end = row_wrap && col_wrap;
      reordered_samples.push_back(r);
      if (row_wrap) begin
        rd_row = 0;
        rd_col = col_wrap ? 0 : rd_col + 1;
      end else begin
        rd_row++;
      end
    end
    bank_mem[fill_bank][wr_pos % BANK_DEPTH] = s;
    wr_pos++;
    if (wr_pos >= block_len) begin
      wr_pos     = 0;
      fill_bank  = fill_bank ^ 1'b1;
      bank_ready = 1'b1;
      rd_row     = 0;
      rd_col     = 0;
    end
  endfunction

  // Drivers: change inputs on the falling edge, hold a request until taken
  always @(negedge clk) begin
    if (calm_left != 0) begin
      calm_left <= calm_left - 1;
    end else if ($urandom_range(149) == 0) begin
      calm_left <= $urandom_range(80, 20);
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_fired) begin
      if (pending_samples.size() != 0 &&
          !(calm_left == 0 && $urandom_range(99) < sender_idle_pct)) begin
        in_bus.valid     <= 1'b1;
        in_bus.sample_in <= pending_samples[0];
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= calm_left != 0 || $urandom_range(99) >= receiver_stall_pct;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      cfg_bus.valid <= 1'b0;
    end else if (!cfg_bus.valid || cfg_fired) begin
      if (pending_reg_writes.size() != 0) begin
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= pending_reg_writes[0].index;
        cfg_bus.data  <= pending_reg_writes[0].data;
      end else begin
        cfg_bus.valid <= 1'b0;
      end
    end
  end

  // Monitor: sample handshakes on the rising edge, predict and check
  always @(posedge clk) begin
    reordered_t want;
    in_fired  <= rst_n && in_bus.valid && in_bus.ready;
    cfg_fired <= rst_n && cfg_bus.valid && cfg_bus.ready;
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          bi_pkg::REG_ROW_COUNT:    rows_used = clamp_dim(cfg_bus.data, MAX_ROWS);
          bi_pkg::REG_COLUMN_COUNT: cols_used = clamp_dim(cfg_bus.data, MAX_COLUMNS);
          default: ;
        endcase
        void'(pending_reg_writes.pop_front());
        reg_writes_taken <= reg_writes_taken + 1;
      end
      if (in_bus.valid && in_bus.ready) begin
        interleave_sample(in_bus.sample_in);
        void'(pending_samples.pop_front());
        samples_taken <= samples_taken + 1;
      end
      if (out_bus.valid && out_bus.ready) begin
        if (reordered_samples.size() == 0) begin
          $error("sample_out: expected no result, got %0d (block_end %0b)",
                 $signed(out_bus.sample_out), out_bus.block_end);
          mismatches++;
        end else begin
          want = reordered_samples.pop_front();
          if (out_bus.sample_out !== want.sample) begin
            $error("sample_out: expected %0d, got %0d",
                   $signed(want.sample), $signed(out_bus.sample_out));
            mismatches++;
          end
          if (out_bus.block_end !== want.block_end) begin
            $error("block_end: expected %0b, got %0b", want.block_end, out_bus.block_end);
            mismatches++;
          end
          results_checked++;
          if (want.block_end) block_ends_seen++;
        end
      end
      pending_results <= reordered_samples.size();
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no request moved for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_sample(logic signed [DATA_WIDTH-1:0] s);
    pending_samples.push_back(s);
    samples_queued++;
  endtask

  task automatic queue_edge_samples();
    foreach (EDGE_SAMPLES[i]) queue_sample(EDGE_SAMPLES[i]);
  endtask

  function automatic logic signed [DATA_WIDTH-1:0] pick_sample();
    if ($urandom_range(9) == 0) return EDGE_SAMPLES[$urandom_range(3)];
    return DATA_WIDTH'($urandom);
  endfunction

  // Keep the matrix within the reset geometry so every read hits an entry
  // written while both banks were filled at that size.
  function automatic logic [bi_pkg::CFG_DATA_W-1:0] pick_dim();
    if ($urandom_range(9) == 0) return '0;
    return bi_pkg::CFG_DATA_W'($urandom_range(RESET_DIM, 1));
  endfunction

  // Wait until every sample is taken and every result is back, then let
  // the pipeline empty before touching the registers.
  task automatic settle();
    while (samples_taken != samples_queued || pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [bi_pkg::CFG_INDEX_W-1:0] idx,
                           logic [bi_pkg::CFG_DATA_W-1:0] val);
    reg_write_t w;
    w.index = idx;
    w.data  = val;
    pending_reg_writes.push_back(w);
    reg_writes_queued++;
    while (reg_writes_taken != reg_writes_queued) @(posedge clk);
  endtask

  task automatic set_pace(pace_t p);
    case (p)
      PACE_SENDER_IDLE:    begin sender_idle_pct = 75; receiver_stall_pct = 0;  end
      PACE_RECEIVER_STALL: begin sender_idle_pct = 0;  receiver_stall_pct = 75; end
      PACE_BOTH_IDLE:      begin sender_idle_pct = 27; receiver_stall_pct = 27; end
      default:             begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
    endcase
  endtask

  initial begin
    int unsigned random_sent;
    int unsigned n;
    int unsigned phase_no;
    random_sent   = 0;
    phase_no      = 0;
    rst_n         = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = bi_pkg::REG_ROW_COUNT;
    cfg_bus.data  = '0;
    in_bus.valid  = 1'b0;
    in_bus.sample_in = '0;
    out_bus.ready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry: a partial first block gives no output yet
    set_pace(PACE_FREE);
    queue_edge_samples();
    settle();

    // Complete two blocks of the reset geometry so that both banks hold
    // every entry that the later geometries can address.
    set_pace(PACE_BOTH_IDLE);
    repeat (2 * RESET_DIM * RESET_DIM - $size(EDGE_SAMPLES)) queue_sample(pick_sample());
    settle();

    // Shrink below the write position: the next sample closes the block,
    // and the read row lies past the new row count and must wrap.
    set_pace(PACE_RECEIVER_STALL);
    queue_edge_samples();
    settle();
    write_reg(bi_pkg::REG_ROW_COUNT, 7'd2);
    write_reg(bi_pkg::REG_COLUMN_COUNT, 7'd3);
    queue_edge_samples();
    settle();

    // Zero rows reads as one: a one-entry block closes on the next sample
    // and leaves every counter at the start of a block.
    set_pace(PACE_SENDER_IDLE);
    write_reg(bi_pkg::REG_ROW_COUNT, 7'd0);
    write_reg(bi_pkg::REG_COLUMN_COUNT, 7'd1);
    queue_sample(pick_sample());
    settle();

    // Oversize rows read as the maximum; one column keeps the reads low
    write_reg(bi_pkg::REG_ROW_COUNT, 7'd65);
    repeat (MAX_ROWS) queue_sample(pick_sample());
    settle();

    // Oversize columns read as the maximum; writes to unused indexes drop
    set_pace(PACE_FREE);
    write_reg(bi_pkg::REG_ROW_COUNT, 7'd1);
    write_reg(bi_pkg::REG_COLUMN_COUNT, 7'd127);
    write_reg(REG_SPARE_LO, 7'd5);
    write_reg(REG_SPARE_HI, 7'd127);
    repeat (MAX_COLUMNS) queue_sample(pick_sample());
    settle();

    // Back to the reset geometry on a block boundary
    write_reg(bi_pkg::REG_ROW_COUNT, bi_pkg::CFG_DATA_W'(RESET_DIM));
    write_reg(bi_pkg::REG_COLUMN_COUNT, bi_pkg::CFG_DATA_W'(RESET_DIM));

    while (random_sent < RANDOM_SAMPLES) begin
      set_pace(pace_t'(phase_no % 4));
      if ($urandom_range(3) != 0) write_reg(bi_pkg::REG_ROW_COUNT, pick_dim());
      if ($urandom_range(3) != 0) write_reg(bi_pkg::REG_COLUMN_COUNT, pick_dim());
      if ($urandom_range(7) == 0) begin
        write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
                  bi_pkg::CFG_DATA_W'($urandom));
      end
      n = $urandom_range(50, 10);
      repeat (n) queue_sample(pick_sample());
      random_sent += n;
      phase_no++;
      settle();
    end

    while (samples_taken != samples_queued || pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d samples, %0d reordered results checked, %0d block ends",
             samples_taken, results_checked, block_ends_seen);
    $display("over %0d register writes, %0d random geometry phases, one side up to 64",
             reg_writes_taken, phase_no);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
